@@ src/c6502pd_pkg.sv @@
// Shared types, opcode constants and the addressing-mode table for the 6502 predecoder.
`default_nettype none

package c6502pd_pkg;

  typedef enum logic [3:0] {
    AM_NONE = 4'd0,
    AM_IMPL = 4'd1,
    AM_INDX = 4'd2,
    AM_ZP   = 4'd3,
    AM_IMM  = 4'd4,
    AM_ACC  = 4'd5,
    AM_ABS  = 4'd6,
    AM_REL  = 4'd7,
    AM_INDY = 4'd8,
    AM_ZPX  = 4'd9,
    AM_ABSY = 4'd10,
    AM_ABSX = 4'd11,
    AM_IND  = 4'd12,
    AM_ZPY  = 4'd13
  } addr_mode_e;

  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_RTI     = 8'h40;
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;
  localparam logic [7:0] OP_RTS     = 8'h60;
  localparam logic [7:0] OP_JMP_IND = 8'h6C;

  // Conditional branches all match xxx10000.
  localparam logic [4:0] BRANCH_LOW_BITS = 5'h10;

  typedef struct packed {
    logic [15:0] instruction_address;
    logic [7:0]  opcode;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  addressing_mode;
    logic [1:0]  length;
    logic        next_valid;
    logic [15:0] next_address;
    logic        target_valid;
    logic [15:0] target_address;
  } out_item_t;

  localparam addr_mode_e MODE_TABLE [256] = '{
    AM_IMPL, AM_INDX, AM_NONE, AM_NONE, AM_NONE, AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_IMM,  AM_ACC,  AM_NONE, AM_NONE, AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_NONE, AM_NONE, AM_NONE, AM_ABSX, AM_ABSX, AM_NONE,
    AM_ABS,  AM_INDX, AM_NONE, AM_NONE, AM_ZP,   AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_IMM,  AM_ACC,  AM_NONE, AM_ABS,  AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_NONE, AM_NONE, AM_NONE, AM_ABSX, AM_ABSX, AM_NONE,
    AM_IMPL, AM_INDX, AM_NONE, AM_NONE, AM_NONE, AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_IMM,  AM_ACC,  AM_NONE, AM_ABS,  AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_NONE, AM_NONE, AM_NONE, AM_ABSX, AM_ABSX, AM_NONE,
    AM_IMPL, AM_INDX, AM_NONE, AM_NONE, AM_NONE, AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_IMM,  AM_ACC,  AM_NONE, AM_IND,  AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_NONE, AM_NONE, AM_NONE, AM_ABSX, AM_ABSX, AM_NONE,
    AM_NONE, AM_INDX, AM_NONE, AM_NONE, AM_ZP,   AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_NONE, AM_IMPL, AM_NONE, AM_ABS,  AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_ZPY,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_IMPL, AM_NONE, AM_NONE, AM_ABSX, AM_NONE, AM_NONE,
    AM_IMM,  AM_INDX, AM_IMM,  AM_NONE, AM_ZP,   AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_IMM,  AM_IMPL, AM_NONE, AM_ABS,  AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_ZPY,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_IMPL, AM_NONE, AM_ABSX, AM_ABSX, AM_ABSY, AM_NONE,
    AM_IMM,  AM_INDX, AM_NONE, AM_NONE, AM_ZP,   AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_IMM,  AM_IMPL, AM_NONE, AM_ABS,  AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_NONE, AM_NONE, AM_NONE, AM_ABSX, AM_ABSX, AM_NONE,
    AM_IMM,  AM_INDX, AM_NONE, AM_NONE, AM_ZP,   AM_ZP,   AM_ZP,   AM_NONE,
    AM_IMPL, AM_IMM,  AM_IMPL, AM_NONE, AM_ABS,  AM_ABS,  AM_ABS,  AM_NONE,
    AM_REL,  AM_INDY, AM_NONE, AM_NONE, AM_NONE, AM_ZPX,  AM_ZPX,  AM_NONE,
    AM_IMPL, AM_ABSY, AM_NONE, AM_NONE, AM_NONE, AM_ABSX, AM_ABSX, AM_NONE
  };

  function automatic logic [1:0] mode_length(addr_mode_e mode);
    logic [1:0] len;
    case (mode)
      AM_IMPL, AM_ACC: len = 2'd1;
      AM_INDX, AM_ZP, AM_IMM, AM_REL, AM_INDY, AM_ZPX, AM_ZPY: len = 2'd2;
      AM_ABS, AM_ABSY, AM_ABSX, AM_IND: len = 2'd3;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ src/cpu6502_opcode_predecode_unit.sv @@
// Top level of the 6502 instruction predecoder: input register, decode, result register.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one instruction per item: its
//   address, opcode and the two bytes that follow. Output channel
//   out_valid_o/out_ready_i carries one result per item: addressing mode,
//   length, fall-through successor and branch/call target.
//   An item passes through the input register and then the result register,
//   with the table lookup and the 16-bit address adds between them.
//   out_valid_o rises once the item has moved into the result register.
//   Throughput is one item per cycle while out_ready_i stays high.
//   When the receiver stalls, the result register holds its item and the input
//   register keeps accepting until it is full too; in_ready_o then drops.
//   Reset clears both valid flags; in_ready_o stays high, so an item can be
//   accepted as soon as reset is released.
`default_nettype none

module cpu6502_opcode_predecode_unit
  import c6502pd_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_item_o
);

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t dec_result;
  logic      out_free;
  logic      s1_advance;
  logic      in_take;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !out_free);
  assign out_valid_d = s1_advance || (out_valid_q && !out_ready_i);

  c6502pd_decode u_decode (
    .item_i   (s1_item_q),
    .result_o (dec_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: load only on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
    if (s1_advance) begin
      out_item_q <= dec_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ src/c6502pd_decode.sv @@
// Combinational predecode of one instruction: mode, length and successor addresses.
`default_nettype none

module c6502pd_decode
  import c6502pd_pkg::*;
(
  input  in_item_t  item_i,
  output out_item_t result_o
);

  addr_mode_e  mode;
  logic [1:0]  len;
  logic [15:0] addr;
  logic [15:0] word;
  logic [15:0] offset;
  logic        is_branch;

  assign addr      = item_i.instruction_address;
  assign word      = {item_i.operand_high, item_i.operand_low};
  assign offset    = {{8{item_i.operand_low[7]}}, item_i.operand_low};
  assign mode      = MODE_TABLE[item_i.opcode];
  assign len       = mode_length(mode);
  assign is_branch = (item_i.opcode[4:0] == BRANCH_LOW_BITS);

  always_comb begin
    result_o                 = '0;
    result_o.addressing_mode = mode;
    result_o.length          = len;

    if (mode != AM_NONE) begin
      if (item_i.opcode == OP_BRK) begin
        // skip the padding byte after BRK
        result_o.next_valid   = 1'b1;
        result_o.next_address = addr + 16'd2;
      end else if (item_i.opcode == OP_JMP_ABS) begin
        result_o.next_valid   = 1'b1;
        result_o.next_address = word;
      end else if (item_i.opcode == OP_RTI || item_i.opcode == OP_RTS ||
                   item_i.opcode == OP_JMP_IND) begin
        result_o.next_valid   = 1'b0;
      end else begin
        result_o.next_valid   = 1'b1;
        result_o.next_address = addr + {14'd0, len};
      end
    end

    if (is_branch) begin
      result_o.target_valid   = 1'b1;
      result_o.target_address = addr + 16'd2 + offset;
    end else if (item_i.opcode == OP_JSR) begin
      result_o.target_valid   = 1'b1;
      result_o.target_address = word;
    end
  end

endmodule

`default_nettype wire

@@ src/c6502pd_checker.sv @@
// Port-level checks for the 6502 predecoder, bound to its top level.
`default_nettype none

module c6502pd_checker
  import c6502pd_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result stays valid
  a_out_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_hold_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // input backpressure only when the result side is stalled
  a_ready_low_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // an accepted item reaches the output when the result side is not stalled
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind cpu6502_opcode_predecode_unit c6502pd_checker u_checker (.*);

`default_nettype wire
